### hw/rtl/lsp_pkg.sv
// lsp_pkg: shared constants, command and register codes, and types of the
// looping sample player. Used by every other file of the block; no dependencies.
`default_nettype none

package lsp_pkg;

    // storage and fixed-point format
    localparam int MEM_DEPTH    = 262144;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);
    localparam int FRAC_BITS    = 12;
    localparam int POS_INT_BITS = 19;
    localparam int POS_W        = POS_INT_BITS + FRAC_BITS;

    // field widths
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 18;
    localparam int SAMPLE_W = 16;
    localparam int PITCH_W  = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PLAY    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // configuration port
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_PITCH = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;
    localparam logic [1:0] REG_END   = 2'd2;

    // register reset values
    localparam logic [PITCH_W-1:0] PITCH_RST = 16'd256;
    localparam logic [ADDR_W-1:0]  START_RST = 18'd0;
    localparam logic [ADDR_W-1:0]  END_RST   = 18'h3FFFF;

    typedef logic [POS_W-1:0]        t_pos;
    typedef logic [POS_INT_BITS-1:0] t_pos_int;
    typedef logic [MEM_AW-1:0]       t_mem_addr;

    // configuration as seen by the position unit
    typedef struct packed {
        logic [PITCH_W-1:0] pitch_code;
        logic [ADDR_W-1:0]  loop_start;
        logic [ADDR_W-1:0]  loop_end;
    } t_cfg;

    // position update strobes
    typedef struct packed {
        logic play;
        logic restart;
    } t_pos_ctl;

endpackage

`default_nettype wire

### hw/rtl/lsp_item_if.sv
// lsp_item_if: input channel of the looping sample player (valid, ready, item).
// Depends on lsp_pkg for field widths.
`default_nettype none

interface lsp_item_if;
    logic                                valid;
    logic                                ready;
    logic [lsp_pkg::CMD_W-1:0]           cmd;
    logic [lsp_pkg::ADDR_W-1:0]          wr_address;
    logic signed [lsp_pkg::SAMPLE_W-1:0] wr_value;

    modport source (output valid, cmd, wr_address, wr_value, input ready);
    modport sink   (input valid, cmd, wr_address, wr_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/lsp_result_if.sv
// lsp_result_if: result channel of the looping sample player (valid, ready, item).
// Depends on lsp_pkg for field widths.
`default_nettype none

interface lsp_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [lsp_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/looping_sample_player.sv
// looping_sample_player: top level with configuration registers, item handshake
// and result register. Depends on lsp_pkg, lsp_item_if, lsp_result_if, lsp_mem, lsp_pos.
`default_nettype none

// Plays a 16-bit sample table at a variable pitch, looping between loop_start
// and loop_end. Items are taken one per clock: a write item stores a sample, a
// restart item sets the position to loop_start, and a play item reads the sample
// at the integer position and steps the position by 0.5 + pitch_code/4096. The
// position update is a combinational add, compare and subtract, so play items can
// follow each other on every cycle. The sample of a play item comes out of the
// memory read register in the cycle after acceptance and is offered from the result
// register once that register is free; i_item.ready drops only while both of these
// hold items and the result sink stalls. The sample memory is not cleared at reset
// and needs no start-up pass; reading an unwritten entry returns arbitrary data.
// Configuration registers are at byte addresses 0 (pitch_code), 4 (loop_start)
// and 8 (loop_end) and should be written only while no play item is in flight.

module looping_sample_player (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    lsp_item_if.sink                           i_item,
    lsp_result_if.source                       o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lsp_pkg::APB_AW-1:0]    paddr,
    input  wire logic [lsp_pkg::APB_DW-1:0]    pwdata,
    output logic      [lsp_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    logic [lsp_pkg::PITCH_W-1:0]  r_pitch;
    logic [lsp_pkg::ADDR_W-1:0]   r_start;
    logic [lsp_pkg::ADDR_W-1:0]   r_end;
    logic                         r_s1_valid;
    logic                         n_s1_valid;
    logic                         r_o_valid;
    logic                         n_o_valid;
    logic [lsp_pkg::SAMPLE_W-1:0] r_o_data;
    logic [lsp_pkg::SAMPLE_W-1:0] w_rd_data;
    logic [1:0]                   w_reg_idx;
    logic                         w_cfg_wr;
    logic                         w_acc;
    logic                         w_acc_play;
    logic                         w_acc_write;
    logic                         w_s1_move;
    lsp_pkg::t_cfg                w_cfg;
    lsp_pkg::t_pos_ctl            w_ctl;
    lsp_pkg::t_mem_addr           w_rd_addr;

    // configuration registers
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= lsp_pkg::PITCH_RST;
            r_start <= lsp_pkg::START_RST;
            r_end   <= lsp_pkg::END_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                lsp_pkg::REG_PITCH: r_pitch <= pwdata[lsp_pkg::PITCH_W-1:0];
                lsp_pkg::REG_START: r_start <= pwdata[lsp_pkg::ADDR_W-1:0];
                lsp_pkg::REG_END:   r_end   <= pwdata[lsp_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_reg_idx)
            lsp_pkg::REG_PITCH: prdata = lsp_pkg::APB_DW'(r_pitch);
            lsp_pkg::REG_START: prdata = lsp_pkg::APB_DW'(r_start);
            lsp_pkg::REG_END:   prdata = lsp_pkg::APB_DW'(r_end);
            default:            prdata = '0;
        endcase
    end

    assign w_cfg.pitch_code = r_pitch;
    assign w_cfg.loop_start = r_start;
    assign w_cfg.loop_end   = r_end;

    // item handshake; read stage moves on when the result register frees up
    assign w_s1_move    = r_s1_valid && (!r_o_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || w_s1_move;
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_acc_play   = w_acc && (i_item.cmd == lsp_pkg::CMD_PLAY);
    assign w_acc_write  = w_acc && (i_item.cmd == lsp_pkg::CMD_WRITE);

    assign w_ctl.play    = w_acc_play;
    assign w_ctl.restart = w_acc && (i_item.cmd == lsp_pkg::CMD_RESTART);

    lsp_pos u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_ctl     (w_ctl),
        .o_rd_addr (w_rd_addr)
    );

    lsp_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_acc_write),
        .i_wr_addr (lsp_pkg::t_mem_addr'(i_item.wr_address)),
        .i_wr_data (i_item.wr_value),
        .i_rd_en   (w_acc_play),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // read stage and result register valid flags
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_acc_play) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (w_s1_move) begin
            n_o_valid = 1'b1;
        end else if (o_result.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    // result data
    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_o_data <= w_rd_data;
        end
    end

    assign o_result.valid      = r_o_valid;
    assign o_result.sample_out = r_o_data;

    // a play item always lands in the read stage
    a_play_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_acc_play && i_rst_n) |-> r_s1_valid)
        else $error("accepted play item missing from read stage");

    // items other than play never create a result
    a_other_no_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(w_acc && !w_acc_play && i_rst_n) && !$past(r_s1_valid)) |-> !r_s1_valid)
        else $error("non-play item produced a result");

    // no item taken while both result stages are full and stalled
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !o_result.ready) |-> !i_item.ready)
        else $error("item accepted with no room for its result");

endmodule

`default_nettype wire

### hw/rtl/lsp_mem.sv
// lsp_mem: sample memory, one write port and one read port with registered data.
// Depends on lsp_pkg for depth and widths.
`default_nettype none

module lsp_mem (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire lsp_pkg::t_mem_addr             i_wr_addr,
    input  wire logic [lsp_pkg::SAMPLE_W-1:0]   i_wr_data,
    input  wire logic                           i_rd_en,
    input  wire lsp_pkg::t_mem_addr             i_rd_addr,
    output logic      [lsp_pkg::SAMPLE_W-1:0]   o_rd_data
);

    logic [lsp_pkg::SAMPLE_W-1:0] r_mem [lsp_pkg::MEM_DEPTH];
    logic [lsp_pkg::SAMPLE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/lsp_pos.sv
// lsp_pos: play position register and its step, loop wrap and clamp logic.
// Depends on lsp_pkg for the fixed-point format and the t_cfg / t_pos_ctl types.
`default_nettype none

module lsp_pos (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lsp_pkg::t_cfg       i_cfg,
    input  wire lsp_pkg::t_pos_ctl   i_ctl,
    output lsp_pkg::t_mem_addr       o_rd_addr
);

    lsp_pkg::t_pos     r_pos;
    lsp_pkg::t_pos     n_pos;
    lsp_pkg::t_pos     w_step;
    lsp_pkg::t_pos     w_sum;
    lsp_pkg::t_pos     w_start_pos;
    lsp_pkg::t_pos     w_wrapped;
    lsp_pkg::t_pos     w_pos1;
    lsp_pkg::t_pos_int w_len;
    lsp_pkg::t_pos_int w_start_ext;
    lsp_pkg::t_pos_int w_end_ext;
    lsp_pkg::t_pos_int w_sum_int;
    lsp_pkg::t_pos_int w_pos1_int;

    // step is one half plus pitch_code/4096 samples
    assign w_step = (lsp_pkg::t_pos'(1) << (lsp_pkg::FRAC_BITS - 1))
                  + (lsp_pkg::t_pos'(i_cfg.pitch_code) << (lsp_pkg::FRAC_BITS - 12));

    assign w_start_ext = lsp_pkg::t_pos_int'(i_cfg.loop_start);
    assign w_end_ext   = lsp_pkg::t_pos_int'(i_cfg.loop_end);
    assign w_start_pos = lsp_pkg::t_pos'(i_cfg.loop_start) << lsp_pkg::FRAC_BITS;

    // loop length, only meaningful when start <= end
    assign w_len = w_end_ext - w_start_ext + lsp_pkg::t_pos_int'(1);

    assign w_sum     = r_pos + w_step;
    assign w_sum_int = w_sum[lsp_pkg::POS_W-1:lsp_pkg::FRAC_BITS];
    assign w_wrapped = w_sum - (lsp_pkg::t_pos'(w_len) << lsp_pkg::FRAC_BITS);

    // one loop length back when past the end, start point for an inverted loop
    always_comb begin
        if (w_sum_int > w_end_ext) begin
            w_pos1 = (w_start_ext <= w_end_ext) ? w_wrapped : w_start_pos;
        end else begin
            w_pos1 = w_sum;
        end
    end

    assign w_pos1_int = w_pos1[lsp_pkg::POS_W-1:lsp_pkg::FRAC_BITS];

    // next position
    always_comb begin
        n_pos = r_pos;
        if (i_ctl.restart) begin
            n_pos = w_start_pos;
        end else if (i_ctl.play) begin
            n_pos = (w_pos1_int < w_start_ext) ? w_start_pos : w_pos1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // integer part, wrapped to the memory depth
    assign o_rd_addr = lsp_pkg::t_mem_addr'(r_pos[lsp_pkg::POS_W-1:lsp_pkg::FRAC_BITS]);

endmodule

`default_nettype wire
